// ===== rtl/shcpb_pkg.sv =====
// Shared types and constants for the serial hex command pin bridge.
// Holds result kinds, command characters and the job and memory request structs.
// No dependencies.
package shcpb_pkg;

	localparam int SeqDepthDefault = 256;
	localparam int InTdataW        = 40;
	localparam int OutTdataW       = 88;

	localparam logic        OP_BYTE        = 1'b0;
	localparam logic        OP_TICK        = 1'b1;
	localparam logic [31:0] SEQ_FILL       = 32'hAA00_0000;
	localparam logic [7:0]  SEQ_REMAIN_RST = 8'd5;

	// command and digit characters
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_CARET = 8'h5E;

	typedef enum logic [2:0] {
		KIND_CHAR  = 3'd0,
		KIND_PINS  = 3'd1,
		KIND_RESET = 3'd2,
		KIND_SHIFT = 3'd3,
		KIND_SEQ   = 3'd4,
		KIND_MODE  = 3'd5,
		KIND_MARK  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_PINS = 2'd0,
		MODE_TWI  = 2'd1,
		MODE_TEST = 2'd2
	} link_mode_t;

	// all results caused by one request: optional leading result, one
	// character, then up to eight hex digits of word
	typedef struct packed {
		logic        has_pre;
		kind_t       pre_kind;
		logic [2:0]  pins;
		logic [5:0]  count;
		link_mode_t  mode;
		logic [31:0] word;
		logic        use_mem;
		kind_t       ch_kind;
		logic [7:0]  ch;
		logic [3:0]  ndig;
	} job_t;

	typedef struct packed {
		logic        wr_en;
		logic        rd_en;
		logic [7:0]  addr;
		logic [31:0] wr_data;
	} mem_req_t;

endpackage

// ===== rtl/shcpb_seq_mem.sv =====
// Sequence word store with registered read and per-entry valid bits.
// Entries never written read as SEQ_FILL ORed with the entry index. Uses shcpb_pkg.
module shcpb_seq_mem import shcpb_pkg::*; #(
	parameter int SEQ_DEPTH = SeqDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    req,
	output logic [31:0] rd_data
);

	localparam int AW = $clog2(SEQ_DEPTH);

	logic [31:0]          mem [SEQ_DEPTH];
	logic [SEQ_DEPTH-1:0] vld_q;
	logic [31:0]          rd_q;
	logic                 rd_vld_q;
	logic [AW-1:0]        rd_addr_q;
	logic [AW-1:0]        addr;

	assign addr = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q      <= mem[addr];
			rd_addr_q <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : (SEQ_FILL | 32'(rd_addr_q));

endmodule

// ===== rtl/shcpb_exec.sv =====
// Command decoder and architectural state (accumulator, data word, sequence
// index and count). Builds one job per request. Uses shcpb_pkg.
module shcpb_exec import shcpb_pkg::*; #(
	parameter int SEQ_DEPTH = SeqDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        exec,
	input  logic        tick,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] in_bits,
	output logic        job_emit,
	output job_t        job,
	output mem_req_t    mem_req
);

	logic [31:0] accum_q, accum_d;
	logic [31:0] data_q, data_d;
	logic [7:0]  seq_index_q, seq_index_d;
	logic [7:0]  seq_remain_q, seq_remain_d;
	logic        digit_ok;
	logic [3:0]  digit;
	logic        in_range;
	logic [4:0]  len;

	assign in_range = {1'b0, seq_index_q} < 9'(SEQ_DEPTH);
	assign len      = accum_q[4:0];

	always_comb begin
		digit_ok = 1'b1;
		digit    = '0;
		priority if (rx_byte >= CH_0 && rx_byte <= CH_9) begin
			digit = rx_byte[3:0];
		end else if ((rx_byte >= CH_UA && rx_byte <= CH_UF) ||
				(rx_byte >= CH_LA && rx_byte <= CH_LF)) begin
			digit = rx_byte[3:0] + 4'd9;
		end else begin
			digit_ok = 1'b0;
		end
	end

	always_comb begin
		accum_d      = accum_q;
		data_d       = data_q;
		seq_index_d  = seq_index_q;
		seq_remain_d = seq_remain_q;
		job_emit     = 1'b1;
		job          = '0;
		job.ch_kind  = KIND_CHAR;
		job.ch       = rx_byte;
		mem_req         = '0;
		mem_req.addr    = seq_index_q;
		mem_req.wr_data = accum_q;

		if (tick) begin
			if (seq_remain_q != '0) begin
				job.has_pre    = 1'b1;
				job.pre_kind   = KIND_SEQ;
				job.use_mem    = in_range;
				job.ch_kind    = KIND_MARK;
				job.ch         = CH_CARET;
				mem_req.rd_en  = exec && in_range;
				seq_index_d    = seq_index_q + 8'd1;
				seq_remain_d   = seq_remain_q - 8'd1;
			end else begin
				job_emit = 1'b0;
			end
		end else if (digit_ok) begin
			accum_d = {accum_q[27:0], digit};
		end else begin
			unique case (rx_byte)
				CH_HASH: begin
					data_d  = accum_q;
					accum_d = '0;
				end
				CH_EQ: begin
					job.has_pre  = 1'b1;
					job.pre_kind = KIND_PINS;
					job.pins     = accum_q[2:0];
					accum_d      = '0;
				end
				CH_M: begin
					job.has_pre  = 1'b1;
					job.pre_kind = KIND_RESET;
					job.pins     = {2'b00, |accum_q[7:0]};
					accum_d      = '0;
				end
				CH_GT: begin
					job.has_pre  = 1'b1;
					job.pre_kind = KIND_SHIFT;
					job.word     = data_q;
					job.count    = accum_q[5:0];
					accum_d      = '0;
				end
				CH_LT: begin
					// zero length gives an empty mask
					data_d   = in_bits & ((32'd1 << len) - 32'd1);
					job.word = data_d;
					priority if (accum_q > 32'd16) begin
						job.ndig = 4'd8;
					end else if (accum_q > 32'd8) begin
						job.ndig = 4'd4;
					end else begin
						job.ndig = 4'd2;
					end
					accum_d = '0;
				end
				CH_BANG, CH_PCT, CH_QUEST: begin
					job.has_pre  = 1'b1;
					job.pre_kind = KIND_MODE;
					job.mode     = (rx_byte == CH_BANG) ? MODE_PINS :
						(rx_byte == CH_PCT) ? MODE_TWI : MODE_TEST;
				end
				CH_AMP: begin
					seq_index_d = accum_q[7:0];
					accum_d     = '0;
				end
				CH_BAR: begin
					mem_req.wr_en = exec && in_range;
					seq_index_d   = seq_index_q + 8'd1;
					accum_d       = '0;
				end
				CH_STAR: begin
					seq_remain_d = accum_q[7:0];
					accum_d      = '0;
				end
				CH_DOT: begin
					job_emit = 1'b0;
				end
				default: begin
					// plain echo
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			data_q       <= '0;
			seq_index_q  <= '0;
			seq_remain_q <= SEQ_REMAIN_RST;
		end else if (exec) begin
			accum_q      <= accum_d;
			data_q       <= data_d;
			seq_index_q  <= seq_index_d;
			seq_remain_q <= seq_remain_d;
		end
	end

endmodule

// ===== rtl/shcpb_out.sv =====
// Result register and sequencer: holds one job and emits its results one per
// cycle while tready is high (leading result, character, hex digits). Uses shcpb_pkg.
module shcpb_out import shcpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        job_emit,
	input  job_t        job,
	input  logic [31:0] mem_rd,
	input  logic        tready,
	output logic        tvalid,
	output logic        tlast,
	output kind_t       kind,
	output logic [7:0]  char_value,
	output logic [2:0]  pin_levels,
	output logic [31:0] shift_word,
	output logic [5:0]  shift_count,
	output logic [31:0] seq_word,
	output logic [1:0]  link_mode,
	output logic        done
);

	job_t       job_s2;
	logic       valid_s2;
	logic [3:0] pos_q;
	logic [3:0] last_pos;
	logic [3:0] p;
	logic [3:0] sh;
	logic [3:0] nib;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return (d > 4'd9) ? (CH_UA + 8'(d - 4'd10)) : (CH_0 + 8'(d));
	endfunction

	assign last_pos = 4'(job_s2.has_pre) + job_s2.ndig;
	assign p        = pos_q - 4'(job_s2.has_pre);
	assign sh       = job_s2.ndig - p;
	assign nib      = 4'(job_s2.word >> {sh, 2'b00});

	assign tvalid = valid_s2;
	assign tlast  = (pos_q == last_pos);
	assign done   = valid_s2 && tready && tlast;

	always_comb begin
		kind        = KIND_CHAR;
		char_value  = '0;
		pin_levels  = '0;
		shift_word  = '0;
		shift_count = '0;
		seq_word    = '0;
		link_mode   = '0;
		if (job_s2.has_pre && pos_q == '0) begin
			kind        = job_s2.pre_kind;
			pin_levels  = job_s2.pins;
			shift_count = job_s2.count;
			link_mode   = job_s2.mode;
			if (job_s2.pre_kind == KIND_SHIFT) begin
				shift_word = job_s2.word;
			end
			if (job_s2.use_mem) begin
				seq_word = mem_rd;
			end
		end else if (p == '0) begin
			kind       = job_s2.ch_kind;
			char_value = job_s2.ch;
		end else begin
			char_value = hex_char(nib);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_q    <= '0;
		end else if (load) begin
			valid_s2 <= job_emit;
			pos_q    <= '0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && tready) begin
			pos_q <= pos_q + 4'd1;
		end
	end

endmodule

// ===== rtl/serial_hex_command_pin_bridge_top.sv =====
// Top level of the serial hex command pin bridge: input register, command
// decoder, sequence store and result sequencer. Uses shcpb_pkg.
//
// Each request (a host byte or a sequencer tick) is registered, decoded and
// handed to the result register, which presents its first result the cycle
// after the decode cycle and emits one result per cycle while the receiver is
// ready: a request holds the result register until its last result is taken
// and has 1 to 9 results (two for a pin, reset line, shift, mode or live tick
// command, three, five or nine for a read); a '.' or a tick with a zero count
// has no result and passes in its decode cycle. A request with one result
// sustains one request per cycle while the receiver is ready; the next request
// is decoded in the cycle its predecessor's last result is taken. The sequence
// store resets through per-entry valid bits, so it is usable right after reset,
// and its read is registered alongside the job.
module serial_hex_command_pin_bridge_top import shcpb_pkg::*; #(
	parameter int SEQ_DEPTH = SeqDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [InTdataW-1:0]  s_axis_tdata,   // rx_byte, in_bits
	input  logic                 s_axis_tuser,   // operation
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OutTdataW-1:0] m_axis_tdata,   // char_value, pin_levels, shift_word,
	                                             // shift_count, seq_word, link_mode
	output logic [2:0]           m_axis_tuser,   // kind
	output logic                 m_axis_tlast    // last
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic [31:0] bits_s1;
	logic        exec;
	logic        out_done;
	logic        job_emit;
	job_t        job;
	mem_req_t    mem_req;
	logic [31:0] mem_rd;
	kind_t       kind;
	logic [7:0]  char_value;
	logic [2:0]  pin_levels;
	logic [31:0] shift_word;
	logic [5:0]  shift_count;
	logic [31:0] seq_word;
	logic [1:0]  link_mode;

	// decode when the result register is free or drains this cycle
	assign exec          = valid_s1 && (!m_axis_tvalid || out_done);
	assign s_axis_tready = !valid_s1 || exec;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			bits_s1 <= s_axis_tdata[39:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	shcpb_exec #(.SEQ_DEPTH(SEQ_DEPTH)) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.exec     (exec),
		.tick     (op_s1 == OP_TICK),
		.rx_byte  (byte_s1),
		.in_bits  (bits_s1),
		.job_emit (job_emit),
		.job      (job),
		.mem_req  (mem_req)
	);

	shcpb_seq_mem #(.SEQ_DEPTH(SEQ_DEPTH)) u_seq_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

	shcpb_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (exec),
		.job_emit    (job_emit),
		.job         (job),
		.mem_rd      (mem_rd),
		.tready      (m_axis_tready),
		.tvalid      (m_axis_tvalid),
		.tlast       (m_axis_tlast),
		.kind        (kind),
		.char_value  (char_value),
		.pin_levels  (pin_levels),
		.shift_word  (shift_word),
		.shift_count (shift_count),
		.seq_word    (seq_word),
		.link_mode   (link_mode),
		.done        (out_done)
	);

	assign m_axis_tuser = kind;
	assign m_axis_tdata = {5'b0, link_mode, seq_word, shift_count, shift_word,
		pin_levels, char_value};

	// a sequence word is never the last result of its tick
	a_seq_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_SEQ) |-> !m_axis_tlast)
		else $error("sequence word marked last");

	// the marker always closes its run
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_MARK) |-> m_axis_tlast)
		else $error("marker not last");

	// a taken sequence word is followed by its marker
	a_seq_then_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_SEQ) |=>
		(m_axis_tvalid && m_axis_tuser == KIND_MARK))
		else $error("marker missing after sequence word");

	// a stalled input side means a request is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid))
		else $error("input stalled without a held request");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for serial_hex_command_pin_bridge_top: drives host bytes and
// sequencer ticks, predicts every result in a scoreboard class and checks the output.
// Depends on shcpb_pkg and the bridge RTL.
module tb_top;
	import shcpb_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [2:0]  pins;
		logic [31:0] sword;
		logic [5:0]  scount;
		logic [31:0] seqw;
		link_mode_t  mode;
		logic        last;
	} bridge_result_t;

	class bridge_scoreboard;
		logic [31:0]    accum;
		logic [31:0]    latched_word;
		logic [31:0]    seq_mem [SeqDepthDefault];
		logic [7:0]     seq_ptr;
		logic [7:0]     seq_left;
		bridge_result_t expected_results [$];
		bridge_result_t burst [$];
		int             errors;
		int             n_requests;
		int             n_results;
		int             n_fired_ticks;
		int             n_reads;

		function new();
			accum        = '0;
			latched_word = '0;
			seq_ptr      = '0;
			seq_left     = SEQ_REMAIN_RST;
			for (int i = 0; i < SeqDepthDefault; i++)
				seq_mem[i] = SEQ_FILL | 32'(i);
			errors        = 0;
			n_requests    = 0;
			n_results     = 0;
			n_fired_ticks = 0;
			n_reads       = 0;
		endfunction

		function int digit_of(logic [7:0] c);
			if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
			if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
			if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
			return -1;
		endfunction

		function logic [7:0] hex_char(logic [3:0] d);
			return (d > 4'd9) ? CH_UA + 8'(d - 4'd10) : CH_0 + 8'(d);
		endfunction

		function void emit(kind_t k, logic [7:0] ch, logic [2:0] pins = '0,
				logic [31:0] sword = '0, logic [5:0] scount = '0,
				logic [31:0] seqw = '0, link_mode_t mode = MODE_PINS);
			bridge_result_t r;
			r.kind   = k;
			r.ch     = ch;
			r.pins   = pins;
			r.sword  = sword;
			r.scount = scount;
			r.seqw   = seqw;
			r.mode   = mode;
			r.last   = 1'b0;
			burst.push_back(r);
		endfunction

		// predict the results of one accepted request and queue them
		function void note_request(logic op, logic [7:0] c, logic [31:0] bits);
			int          d;
			int          ndig;
			logic [4:0]  len;
			n_requests++;
			burst.delete();
			if (op == OP_TICK) begin
				if (seq_left != 0) begin
					emit(KIND_SEQ, 8'h00, '0, '0, '0, seq_mem[seq_ptr]);
					emit(KIND_MARK, CH_CARET);
					seq_ptr++;
					seq_left--;
					n_fired_ticks++;
				end
			end else begin
				d = digit_of(c);
				if (d >= 0) begin
					accum = (accum << 4) | 32'(d);
					emit(KIND_CHAR, c);
				end else begin
					case (c)
						CH_HASH: begin
							latched_word = accum;
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_EQ: begin
							emit(KIND_PINS, 8'h00, accum[2:0]);
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_M: begin
							emit(KIND_RESET, 8'h00, {2'b00, accum[7:0] != 8'h00});
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_GT: begin
							emit(KIND_SHIFT, 8'h00, '0, latched_word, accum[5:0]);
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_LT: begin
							len = accum[4:0];
							latched_word = (len == 0) ? '0 : bits & ((32'd1 << len) - 32'd1);
							emit(KIND_CHAR, c);
							ndig = (accum > 16) ? 8 : (accum > 8) ? 4 : 2;
							for (int i = ndig - 1; i >= 0; i--)
								emit(KIND_CHAR, hex_char(latched_word[4*i +: 4]));
							accum = '0;
							n_reads++;
						end
						CH_DOT: ;
						CH_BANG, CH_PCT, CH_QUEST: begin
							emit(KIND_MODE, 8'h00, '0, '0, '0, '0,
								(c == CH_BANG) ? MODE_PINS : (c == CH_PCT) ? MODE_TWI : MODE_TEST);
							emit(KIND_CHAR, c);
						end
						CH_AMP: begin
							seq_ptr = accum[7:0];
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_BAR: begin
							seq_mem[seq_ptr] = accum;
							seq_ptr++;
							emit(KIND_CHAR, c);
							accum = '0;
						end
						CH_STAR: begin
							seq_left = accum[7:0];
							emit(KIND_CHAR, c);
							accum = '0;
						end
						default: emit(KIND_CHAR, c);
					endcase
				end
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i])
				expected_results.push_back(burst[i]);
		endfunction

		function void check_result(logic [2:0] kind, logic [OutTdataW-1:0] td, logic last);
			bridge_result_t got;
			bridge_result_t want;
			got.kind   = kind_t'(kind);
			got.ch     = td[7:0];
			got.pins   = td[10:8];
			got.sword  = td[42:11];
			got.scount = td[48:43];
			got.seqw   = td[80:49];
			got.mode   = link_mode_t'(td[82:81]);
			got.last   = last;
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d char %h last %b", kind, got.ch, last);
				return;
			end
			want = expected_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch (expected/actual): kind %0d/%0d char %h/%h pins %h/%h",
						want.kind, got.kind, want.ch, got.ch, want.pins, got.pins);
					$display("  shift %h,%0d/%h,%0d seq %h/%h mode %0d/%0d last %b/%b",
						want.sword, want.scount, got.sword, got.scount,
						want.seqw, got.seqw, want.mode, got.mode, want.last, got.last);
				end
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InTdataW-1:0]  s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutTdataW-1:0] m_axis_tdata;
	logic [2:0]           m_axis_tuser;
	logic                 m_axis_tlast;

	bridge_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_left     = 0;
	int n_sent        = 0;

	serial_hex_command_pin_bridge_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	task automatic send_req(logic op, logic [7:0] c, logic [31:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {bits, c};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(op, c, bits);
		n_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_req(OP_BYTE, c, $urandom);
	endtask

	task automatic send_tick();
		send_req(OP_TICK, 8'($urandom_range(255)), $urandom);
	endtask

	// hex digits of value, mixed case, with an occasional leading zero
	task automatic send_number(logic [31:0] value);
		int          ndig;
		logic [3:0]  d;
		ndig = 1;
		for (int i = 1; i < 8; i++)
			if (value[4*i +: 4] != 0) ndig = i + 1;
		if (ndig < 8 && $urandom_range(3) == 0) ndig++;
		for (int i = ndig - 1; i >= 0; i--) begin
			d = value[4*i +: 4];
			if (d < 10) send_char(CH_0 + 8'(d));
			else send_char(($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 4'd10));
		end
	endtask

	task automatic send_random_command();
		logic [7:0]  cmds [12];
		logic [7:0]  cmd;
		logic [31:0] value;
		int          r;
		cmds = '{CH_HASH, CH_EQ, CH_M, CH_GT, CH_LT, CH_BANG, CH_PCT, CH_QUEST,
			CH_AMP, CH_BAR, CH_STAR, CH_DOT};
		r = $urandom_range(99);
		if (r < 12) begin
			send_tick();
		end else if (r < 22) begin
			send_char(8'($urandom_range(255)));
		end else begin
			cmd = cmds[$urandom_range(11)];
			case (cmd)
				CH_LT:   value = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
				CH_EQ:   value = $urandom_range(15);
				CH_M:    value = ($urandom_range(2) == 0) ? 32'h100 : $urandom_range(511);
				CH_GT:   value = $urandom_range(255);
				CH_AMP:  value = $urandom_range(255);
				CH_STAR: value = $urandom_range(6);
				default: value = $urandom;
			endcase
			if ($urandom_range(5) != 0)
				send_number(value);
			send_req(OP_BYTE, cmd, $urandom);
		end
	endtask

	task automatic run_random(int count);
		int target;
		target = n_sent + count;
		while (n_sent < target)
			send_random_command();
	endtask

	// stop offering requests until every expected result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 84;
		// opening tick uses the reset sequence contents
		send_tick();
		send_char(CH_UF);
		send_char(CH_EQ);
		send_char(CH_M);
		send_char(CH_LA);
		send_char(CH_HASH);
		send_char(CH_GT);
		// widest read (31 bits) with all samples high, then a zero-length read
		send_char(CH_0 + 8'd1);
		send_char(CH_UF);
		send_req(OP_BYTE, CH_LT, '1);
		send_char(CH_0 + 8'd3);
		send_char(CH_LF);
		send_char(CH_GT);
		send_req(OP_BYTE, CH_LT, '1);
		send_char(CH_BANG);
		send_char(CH_PCT);
		send_char(CH_QUEST);
		send_char(CH_DOT);
		send_char(8'hFF);
		// write at the top index, which wraps the pointer to zero
		send_char(CH_UF);
		send_char(CH_LF);
		send_char(CH_AMP);
		send_char(CH_BAR);
		send_char(CH_0 + 8'd2);
		send_char(CH_STAR);
		repeat (3) send_tick();
		run_random(70);
		drain();

		send_idle_pct = 84;
		recv_idle_pct = 16;
		run_random(90);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 300;
		run_random(40);
		run_random(50);
		drain();

		$display("Covered %0d requests (%0d live ticks, %0d hex reads), %0d results checked.",
			sb.n_requests, sb.n_fired_ticks, sb.n_reads, sb.n_results);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
